FILE: hdl/rth_pkg.sv
`timescale 1ns / 1ps

package rth_pkg;

    localparam int CH_W       = 8;
    localparam int HUE_W      = 9;
    localparam int FRAC_OUT_W = 17;
    localparam int SUM_W      = 9;
    localparam int DADJ_W     = 11;
    localparam int DIV_DEN_W  = 9;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    // saturation divisor threshold and fold value (sum > 255 gives 510 - sum), hue numerator scale (2 * 60)
    localparam int LIGHT_BIAS = 255;
    localparam int LIGHT_DEN  = 510;
    localparam int HUE_SCALE  = 120;

    // lightness as floor((sum * 2**(f-1) + 127) / 255), exact for any 32-bit operand
    // through the reciprocal ceil(2**39 / 255)
    localparam int          LIGHT_Y_W       = 32;
    localparam int          LIGHT_HALF_BIAS = 127;
    localparam logic [31:0] LIGHT_RECIP     = 32'h80808081;
    localparam int          LIGHT_SHIFT     = 39;

    typedef struct packed {
        logic                valid;
        logic                grey;
        logic [SUM_W-1:0]    sum;
        logic [CH_W-1:0]     delta;
        logic [CH_W-1:0]     den;
        logic [DADJ_W-1:0]   dadj;
    } prep_t;

endpackage

FILE: hdl/rth_prep.sv
`timescale 1ns / 1ps

module rth_prep (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [rth_pkg::CH_W-1:0]  red,
    input  logic [rth_pkg::CH_W-1:0]  green,
    input  logic [rth_pkg::CH_W-1:0]  blue,
    output rth_pkg::prep_t            prep
);
    import rth_pkg::*;

    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } sector_t;

    // stage 1: max, min and winning channel
    logic [CH_W-1:0] mx_next, mn_next;
    sector_t         sec_next;

    logic            v1_reg;
    logic [CH_W-1:0] r1_reg, g1_reg, b1_reg, mx_reg, mn_reg;
    sector_t         sec_reg;

    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sec_next = SEC_RED;
            mx_next  = red;
        end
        else if (green >= blue)
        begin
            sec_next = SEC_GREEN;
            mx_next  = green;
        end
        else
        begin
            sec_next = SEC_BLUE;
            mx_next  = blue;
        end
        mn_next = red;
        if (green < mn_next)
        begin
            mn_next = green;
        end
        if (blue < mn_next)
        begin
            mn_next = blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg  <= red;
            g1_reg  <= green;
            b1_reg  <= blue;
            mx_reg  <= mx_next;
            mn_reg  <= mn_next;
            sec_reg <= sec_next;
        end
    end

    // stage 2: sum, delta, saturation divisor, hue sector offset
    logic [SUM_W-1:0]  sum_next;
    logic [CH_W-1:0]   delta_next, den_next;
    logic [11:0]       d_raw, d_wrap, dl12;
    logic [DADJ_W-1:0] dadj_next;

    logic              v2_reg, grey_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CH_W-1:0]   delta_reg, den_reg;
    logic [DADJ_W-1:0] dadj_reg;

    always_comb
    begin
        sum_next   = {1'b0, mx_reg} + {1'b0, mn_reg};
        delta_next = mx_reg - mn_reg;
        if (sum_next > SUM_W'(LIGHT_BIAS))
        begin
            den_next = CH_W'(SUM_W'(LIGHT_DEN) - sum_next);
        end
        else
        begin
            den_next = sum_next[CH_W-1:0];
        end
        dl12 = {4'b0, delta_next};
        // offset in sixths of a turn scaled by delta, wrapping only occurs in the red sector
        case (sec_reg)
            SEC_RED:   d_raw = {4'b0, g1_reg} - {4'b0, b1_reg};
            SEC_GREEN: d_raw = {4'b0, b1_reg} - {4'b0, r1_reg} + (dl12 << 1);
            SEC_BLUE:  d_raw = {4'b0, r1_reg} - {4'b0, g1_reg} + (dl12 << 2);
            default:   d_raw = '0;
        endcase
        d_wrap    = d_raw + (dl12 << 2) + (dl12 << 1);
        dadj_next = d_raw[11] ? d_wrap[DADJ_W-1:0] : d_raw[DADJ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grey_reg  <= (delta_next == '0);
            sum_reg   <= sum_next;
            delta_reg <= delta_next;
            den_reg   <= den_next;
            dadj_reg  <= dadj_next;
        end
    end

    assign prep.valid = v2_reg;
    assign prep.grey  = grey_reg;
    assign prep.sum   = sum_reg;
    assign prep.delta = delta_reg;
    assign prep.den   = den_reg;
    assign prep.dadj  = dadj_reg;

endmodule

FILE: hdl/rth_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage; needs num < den * 2**QUO_W
module rth_div #(
    parameter int NUM_W = 26,
    parameter int QUO_W = 17
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [NUM_W-1:0]        num,
    input  logic [NUM_W-QUO_W-1:0]  den,
    output logic [QUO_W-1:0]        quo
);
    localparam int REM_W = NUM_W - QUO_W;

    logic [REM_W-1:0] rem_reg  [QUO_W-1];
    logic [REM_W-1:0] dvs_reg  [QUO_W-1];
    logic [QUO_W-1:0] work_reg [QUO_W];

    logic [REM_W-1:0] rem_src  [QUO_W];
    logic [REM_W-1:0] dvs_src  [QUO_W];
    logic [QUO_W-1:0] work_src [QUO_W];

    assign rem_src[0]  = num[NUM_W-1:QUO_W];
    assign dvs_src[0]  = den;
    assign work_src[0] = num[QUO_W-1:0];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        logic [REM_W:0] trial;
        logic           take;

        assign trial = {rem_src[s], work_src[s][QUO_W-1]};
        assign take  = (trial >= {1'b0, dvs_src[s]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                work_reg[s] <= {work_src[s][QUO_W-2:0], take};
            end
        end

        if (s + 1 < QUO_W)
        begin : g_carry
            logic [REM_W:0] diff;

            assign diff = trial - {1'b0, dvs_src[s]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
                    dvs_reg[s] <= dvs_src[s];
                end
            end

            assign rem_src[s+1]  = rem_reg[s];
            assign dvs_src[s+1]  = dvs_reg[s];
            assign work_src[s+1] = work_reg[s];
        end
    end

    assign quo = work_reg[QUO_W-1];

endmodule

FILE: hdl/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps

// rgb to hsl pixel converter
// s_tdata carries one pixel per transfer; m_tdata carries hue, saturation
// and lightness for it, one result transfer per input transfer, in order.
// saturation and lightness are fractions scaled by 2**FRACTION_BITS, kept
// to their 17-bit fields; hue is in whole degrees 0..360, zero for grey.
// from input transfer to m_tvalid a pixel passes two front stages and then
// the restoring dividers, which resolve one quotient bit per stage.
// lightness rides along and is finished by a reciprocal multiply in the
// last stage.
// throughput: one pixel per cycle while m_tready is high.
// the whole pipeline advances together: when a result waits with m_tready
// low, every stage holds and s_tready drops; nothing is lost or repeated.
// reset clears all valid bits; the block is ready right after reset.
module rgb_to_hsl_converter #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [rth_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hue_degrees [8:0], saturation [25:9], lightness [42:26], zero fill
    output logic [rth_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import rth_pkg::*;

    localparam int QUO_W = FRACTION_BITS + 1;
    localparam int NUM_W = FRACTION_BITS + 10;

    logic  en;
    prep_t prep;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    rth_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .red      (s_tdata[CH_W-1:0]),
        .green    (s_tdata[2*CH_W-1:CH_W]),
        .blue     (s_tdata[3*CH_W-1:2*CH_W]),
        .prep     (prep)
    );

    logic [NUM_W-1:0]     sat_num, hue_num;
    logic [DIV_DEN_W-1:0] sat_den, hue_den;
    logic [QUO_W-1:0]     sat_q, hue_q;

    // round to nearest: (2*n*2**f + d) / (2*d)
    assign sat_num   = (NUM_W'(prep.delta) << (FRACTION_BITS + 1)) + NUM_W'(prep.den);
    assign sat_den   = {prep.den, 1'b0};
    assign hue_num   = NUM_W'(prep.dadj) * NUM_W'(HUE_SCALE) + NUM_W'(prep.delta);
    assign hue_den   = {prep.delta, 1'b0};

    rth_div #(.NUM_W(NUM_W), .QUO_W(QUO_W)) u_sat_div (
        .clk (clk),
        .en  (en),
        .num (sat_num),
        .den (sat_den),
        .quo (sat_q)
    );

    rth_div #(.NUM_W(NUM_W), .QUO_W(QUO_W)) u_hue_div (
        .clk (clk),
        .en  (en),
        .num (hue_num),
        .den (hue_den),
        .quo (hue_q)
    );

    // valid and grey flags ride alongside the divider stages
    logic [QUO_W-1:0] vld_reg, vld_next;
    logic [QUO_W-1:0] grey_reg, grey_next;

    assign vld_next  = {vld_reg[QUO_W-2:0], prep.valid};
    assign grey_next = {grey_reg[QUO_W-2:0], prep.grey};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grey_reg <= grey_next;
        end
    end

    // sum waits until the last divider stage, then lightness is registered with it
    logic [QUO_W-2:0][SUM_W-1:0] sum_pipe_reg, sum_pipe_next;
    logic [LIGHT_Y_W-1:0]        light_y;
    logic [2*LIGHT_Y_W-1:0]      light_prod;
    logic [FRAC_OUT_W-1:0]       light_reg, light_next;

    assign sum_pipe_next = {sum_pipe_reg[QUO_W-3:0], prep.sum};
    assign light_y       = (LIGHT_Y_W'(sum_pipe_reg[QUO_W-2]) << (FRACTION_BITS - 1))
                           + LIGHT_Y_W'(LIGHT_HALF_BIAS);
    assign light_prod    = (2*LIGHT_Y_W)'(light_y) * (2*LIGHT_Y_W)'(LIGHT_RECIP);
    assign light_next    = FRAC_OUT_W'(light_prod >> LIGHT_SHIFT);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_pipe_reg <= sum_pipe_next;
            light_reg    <= light_next;
        end
    end

    logic                  grey_out;
    logic [HUE_W-1:0]      hue_out;
    logic [FRAC_OUT_W-1:0] sat_out, light_out;

    assign grey_out  = grey_reg[QUO_W-1];
    assign hue_out   = grey_out ? '0 : HUE_W'(hue_q);
    assign sat_out   = grey_out ? '0 : FRAC_OUT_W'(sat_q);
    assign light_out = light_reg;

    assign m_tvalid = vld_reg[QUO_W-1];
    assign m_tdata  = {(OUT_TDATA_W - HUE_W - 2*FRAC_OUT_W)'(0), light_out, sat_out, hue_out};

endmodule

FILE: test/rgb_to_hsl_converter_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;

    import rth_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_LIMIT   = 2000;
    localparam int FLUSH_CYCLES = FRAC_BITS + 3 + 40;
    localparam int MAX_REPORTS  = 50;

    localparam int SAT_LSB   = HUE_W;
    localparam int LIGHT_LSB = HUE_W + FRAC_OUT_W;

    typedef struct packed {
        logic [HUE_W-1:0]      hue;
        logic [FRAC_OUT_W-1:0] sat;
        logic [FRAC_OUT_W-1:0] light;
    } hsl_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            known;
        hsl_t            hsl;
    } pixel_row_t;

    // known = 1 rows carry a hand-derived result, the rest use the predictor
    localparam int N_ROWS = 23;
    pixel_row_t pixel_rows [N_ROWS] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   17'd0,     17'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{9'd0,   17'd0,     17'd65536}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{9'd0,   17'd65536, 17'd32768}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{9'd120, 17'd65536, 17'd32768}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{9'd240, 17'd65536, 17'd32768}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{9'd60,  17'd65536, 17'd32768}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{9'd180, 17'd65536, 17'd32768}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{9'd300, 17'd65536, 17'd32768}},
        '{8'd128, 8'd128, 8'd128, 1'b0, '0},
        '{8'd255, 8'd0,   8'd1,   1'b0, '0},
        '{8'd255, 8'd0,   8'd2,   1'b0, '0},
        '{8'd1,   8'd0,   8'd0,   1'b0, '0},
        '{8'd254, 8'd255, 8'd255, 1'b0, '0},
        '{8'd255, 8'd128, 8'd0,   1'b0, '0},
        '{8'd100, 8'd200, 8'd50,  1'b0, '0},
        '{8'd10,  8'd20,  8'd30,  1'b0, '0},
        '{8'd200, 8'd100, 8'd150, 1'b0, '0},
        '{8'd255, 8'd1,   8'd1,   1'b0, '0},
        '{8'd127, 8'd128, 8'd128, 1'b0, '0},
        '{8'd128, 8'd127, 8'd127, 1'b0, '0},
        '{8'd0,   8'd128, 8'd255, 1'b0, '0},
        '{8'd1,   8'd1,   8'd0,   1'b0, '0},
        '{8'd255, 8'd254, 8'd254, 1'b0, '0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    hsl_t hsl_expected_q [$];
    int   mismatch_count = 0;
    int   idle_cycles = 0;
    int   results_seen = 0;
    int   hue_360_seen = 0;
    int   grey_seen = 0;
    bit   calm = 1'b0;

    rgb_to_hsl_converter #(
        .FRACTION_BITS(FRAC_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic hsl_t hsl_of(input logic [CH_W-1:0] red, green, blue);
        int             r, g, b, mx, mn, sum, delta, den, t;
        longint         hue_q, sat_q, light_q;
        hsl_t           res;
        r = red;
        g = green;
        b = blue;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        delta = mx - mn;
        light_q = ((longint'(sum) << FRAC_BITS) + 255) / 510;
        hue_q = 0;
        sat_q = 0;
        if (delta != 0)
        begin
            den = (sum > 255) ? 510 - sum : sum;
            sat_q = (2 * (longint'(delta) << FRAC_BITS) + den) / (2 * den);
            // ties for the maximum go to red, then green
            if (mx == r)
                t = 60 * (g - b);
            else if (mx == g)
                t = 60 * (b - r + 2 * delta);
            else
                t = 60 * (r - g + 4 * delta);
            if (t < 0)
                t += 360 * delta;
            hue_q = longint'(2 * t + delta) / longint'(2 * delta);
        end
        res.hue   = hue_q[HUE_W-1:0];
        res.sat   = sat_q[FRAC_OUT_W-1:0];
        res.light = light_q[FRAC_OUT_W-1:0];
        return res;
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99, 0);
        if (calm || p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input hsl_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        hsl_expected_q.insert(hsl_expected_q.size(), want);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (hsl_expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_pixel(output logic [CH_W-1:0] r, g, b);
        int p;
        p = $urandom_range(99, 0);
        r = CH_W'($urandom_range(255, 0));
        g = CH_W'($urandom_range(255, 0));
        b = CH_W'($urandom_range(255, 0));
        if (p < 15)
        begin
            g = r;
            b = r;
        end
        else if (p < 30)
        begin
            // two channels tie
            case ($urandom_range(2, 0))
                0: g = r;
                1: b = g;
                default: b = r;
            endcase
        end
        else if (p < 40)
        begin
            r = $urandom_range(1, 0) ? 8'd255 : 8'd0;
            g = $urandom_range(1, 0) ? 8'd255 : g;
            b = $urandom_range(1, 0) ? 8'd0 : b;
        end
        else if (p < 50)
        begin
            // red on top with blue just above green: hue close to 360
            g = CH_W'($urandom_range(32'(r), 0));
            b = (int'(g) + $urandom_range(3, 1) > int'(r)) ? r :
                CH_W'(32'(g) + $urandom_range(3, 1));
        end
    endtask

    initial
    begin
        logic [CH_W-1:0] r, g, b;
        hsl_t            want;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (pixel_rows[i])
        begin
            want = pixel_rows[i].known ? pixel_rows[i].hsl :
                   hsl_of(pixel_rows[i].red, pixel_rows[i].green, pixel_rows[i].blue);
            send_pixel(pixel_rows[i].red, pixel_rows[i].green, pixel_rows[i].blue, want);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i % 250) >= 180;
            if (i == RANDOM_ITEMS / 2)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            random_pixel(r, g, b);
            send_pixel(r, g, b, hsl_of(r, g, b));
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;
        wait_drained();
        repeat (FLUSH_CYCLES) @(posedge clk);

        $display("covered %0d directed and %0d random pixels, %0d results checked",
                 N_ROWS, RANDOM_ITEMS, results_seen);
        $display("grey results %0d, hue of 360 results %0d", grey_seen, hue_360_seen);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side backpressure, with stall-free stretches while calm
    initial
    begin
        int n;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(40, 1)) @(negedge clk);
            n = pick_gap();
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        hsl_t got;
        hsl_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hue   = m_tdata[HUE_W-1:0];
            got.sat   = m_tdata[SAT_LSB +: FRAC_OUT_W];
            got.light = m_tdata[LIGHT_LSB +: FRAC_OUT_W];
            results_seen++;
            if (hsl_expected_q.size() == 0)
                report_mismatch("result transfer with nothing pending", int'(got.hue), 0);
            else
            begin
                want = hsl_expected_q.pop_front();
                if (want.hue == 360)
                    hue_360_seen++;
                if (want.sat == 0)
                    grey_seen++;
                if (got.hue !== want.hue)
                    report_mismatch("hue_degrees", int'(got.hue), int'(want.hue));
                if (got.sat !== want.sat)
                    report_mismatch("saturation", int'(got.sat), int'(want.sat));
                if (got.light !== want.light)
                    report_mismatch("lightness", int'(got.light), int'(want.light));
            end
        end
    end

    // ends a hung run: no transfer on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", hsl_expected_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

FILE: filelist.f
hdl/rth_pkg.sv
hdl/rth_prep.sv
hdl/rth_div.sv
hdl/rgb_to_hsl_converter.sv
test/rgb_to_hsl_converter_tb.sv
